FILE: rtl/core/tdlcfr_pkg.sv
package tdlcfr_pkg;

	localparam int MaxTaps = 32;
	localparam int TapBits = $clog2(MaxTaps);
	localparam int CntBits = TapBits + 1;
	localparam int SineBits = 12;
	localparam int SineSize = 1 << SineBits;
	localparam int QtrSize = SineSize / 4;
	localparam int SubBits = 12;
	localparam int AccBits = 40;
	localparam real TurnStep = 2.0 * 3.14159265358979323846 / real'(SineSize);

	localparam logic KindLoad = 1'b0;
	localparam logic KindEval = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [4:0]         tap_index;
		logic signed [15:0] gain_re;
		logic signed [15:0] gain_im;
		logic [31:0]        phase_step;
		logic [11:0]        subcarrier;
		logic signed [15:0] tx_re;
		logic signed [15:0] tx_im;
		logic signed [15:0] noise_re;
		logic signed [15:0] noise_im;
	} req_t;

	typedef struct packed {
		logic signed [23:0] chan_re;
		logic signed [23:0] chan_im;
		logic signed [23:0] rx_re;
		logic signed [23:0] rx_im;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_WALK, ST_DRAIN, ST_DRAIN2, ST_DRAIN3, ST_SCALE, ST_RX, ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic rd_en;
		logic [TapBits-1:0] rd_addr;
		logic scale;
		logic rx_mul;
		logic done;
	} cmd_t;

	function automatic logic signed [15:0] sine_entry(input logic [SineBits-1:0] i);
		real v;
		v = 32767.0 * $sin(TurnStep * real'(i));
		return 16'($rtoi(v >= 0.0 ? v + 0.5 : v - 0.5));
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) return 24'sd8388607;
		if (v < -48'sd8388608) return -24'sd8388608;
		return v[23:0];
	endfunction

endpackage

FILE: rtl/core/tdl_channel_frequency_response.sv
// Channel frequency response engine. Pulse start when busy is low. A load
// request (kind 0) gives no result. A subcarrier request keeps busy high
// through the walk over tap_count taps (tap_count above 32 counts as 32),
// the drain, scale, rx and done states; the walk is paced by one shared
// complex multiply-accumulate that reads one stored tap per cycle; out_valid
// is then high for one cycle, in which a new request may already be taken.
// The receiver cannot stall. Write tap_count only while busy is low.
module tdl_channel_frequency_response import tdlcfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic out_valid,
	output rsp_t rsp,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [5:0] cfg_data
);
	logic [5:0] tap_count_q;
	logic [CntBits-1:0] taps;
	logic go, load;
	cmd_t cmd;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tap_count_q <= 6'd1;
		else if (cfg_valid) tap_count_q <= cfg_data;
	end

	assign taps = (tap_count_q > 6'(MaxTaps)) ? CntBits'(MaxTaps) : CntBits'(tap_count_q);
	assign go = start && !busy && req.kind == KindEval;
	assign load = start && !busy && req.kind == KindLoad;

	tdlcfr_ctrl u_ctrl (.clk, .arst_n, .go, .taps, .cmd, .busy);
	tdlcfr_dp u_dp (.clk, .arst_n, .load, .capture(go), .req, .cmd,
		.strobe(out_valid), .rsp);
endmodule

FILE: rtl/core/tdlcfr_ctrl.sv
module tdlcfr_ctrl import tdlcfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [CntBits-1:0] taps,
	output cmd_t cmd,
	output logic busy
);
	state_t state_q, state_d;
	logic [CntBits-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.rd_addr = idx_q[TapBits-1:0];
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (go) begin
					cmd.clear = 1'b1;
					idx_d = '0;
					state_d = (taps == '0) ? ST_DRAIN : ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.rd_en = 1'b1;
				idx_d = idx_q + 1'b1;
				if (idx_d == taps) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = ST_DRAIN3;
			ST_DRAIN3: state_d = ST_SCALE;
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_RX;
			end
			ST_RX: begin
				cmd.rx_mul = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: rtl/core/tdlcfr_dp.sv
module tdlcfr_dp import tdlcfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic capture,
	input  req_t req,
	input  cmd_t cmd,
	output logic strobe,
	output rsp_t rsp
);
	logic signed [15:0] mem_gr [MaxTaps];
	logic signed [15:0] mem_gi [MaxTaps];
	logic [31:0] mem_ph [MaxTaps];
	logic signed [15:0] sine_rom [SineSize];
	logic [SubBits-1:0] k_q;
	logic signed [15:0] tx_re_q, tx_im_q, nz_re_q, nz_im_q;
	logic signed [15:0] gr_s1, gi_s1, gr_s2, gi_s2, sn_s2, cs_s2;
	logic [31:0] ph_s1;
	logic [31:0] phase;
	logic v_s1, v_s2, v_s3;
	logic signed [31:0] p_rc_s3, p_is_s3, p_ic_s3, p_rs_s3;
	logic signed [AccBits-1:0] acc_re_q, acc_im_q;
	logic signed [23:0] h_re_q, h_im_q;
	logic signed [47:0] m_rr_q, m_ii_q, m_ri_q, m_ir_q, sr, si;
	logic [SineBits-1:0] sidx, cidx;

	initial begin
		for (int i = 0; i < SineSize; i++) sine_rom[i] = sine_entry(SineBits'(i));
	end

	always_ff @(posedge clk) begin
		if (load && {1'b0, req.tap_index} < 6'(MaxTaps)) begin
			mem_gr[req.tap_index[TapBits-1:0]] <= req.gain_re;
			mem_gi[req.tap_index[TapBits-1:0]] <= req.gain_im;
			mem_ph[req.tap_index[TapBits-1:0]] <= req.phase_step;
		end
		if (capture) begin
			k_q <= req.subcarrier;
			tx_re_q <= req.tx_re;
			tx_im_q <= req.tx_im;
			nz_re_q <= req.noise_re;
			nz_im_q <= req.noise_im;
		end
		gr_s1 <= mem_gr[cmd.rd_addr];
		gi_s1 <= mem_gi[cmd.rd_addr];
		ph_s1 <= mem_ph[cmd.rd_addr];
	end

	assign phase = ph_s1 * {20'd0, k_q};
	assign sidx = phase[31:32-SineBits];
	assign cidx = sidx + SineBits'(QtrSize);

	always_ff @(posedge clk) begin
		gr_s2 <= gr_s1;
		gi_s2 <= gi_s1;
		sn_s2 <= sine_rom[sidx];
		cs_s2 <= sine_rom[cidx];
		p_rc_s3 <= gr_s2 * cs_s2;
		p_is_s3 <= gi_s2 * sn_s2;
		p_ic_s3 <= gi_s2 * cs_s2;
		p_rs_s3 <= gr_s2 * sn_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			strobe <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			strobe <= cmd.done;
		end
	end

	assign sr = (m_rr_q - m_ii_q) >>> 15;
	assign si = (m_ri_q + m_ir_q) >>> 15;

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s3) begin
			acc_re_q <= acc_re_q + AccBits'(p_rc_s3) + AccBits'(p_is_s3);
			acc_im_q <= acc_im_q + AccBits'(p_ic_s3) - AccBits'(p_rs_s3);
		end
		if (cmd.scale) begin
			h_re_q <= sat24(48'(acc_re_q >>> 15));
			h_im_q <= sat24(48'(acc_im_q >>> 15));
		end
		if (cmd.rx_mul) begin
			m_rr_q <= h_re_q * tx_re_q;
			m_ii_q <= h_im_q * tx_im_q;
			m_ri_q <= h_re_q * tx_im_q;
			m_ir_q <= h_im_q * tx_re_q;
		end
		if (cmd.done) begin
			rsp.chan_re <= h_re_q;
			rsp.chan_im <= h_im_q;
			rsp.rx_re <= sat24(sr + 48'(nz_re_q));
			rsp.rx_im <= sat24(si + 48'(nz_im_q));
		end
	end

`ifndef SYNTHESIS
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !v_s3 && !cmd.done) else $error("clear during work");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> !cmd.done) else $error("double done");
	a_scale_rx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale |=> cmd.rx_mul) else $error("rx step lost");
`endif
endmodule
